// ===== hw/rtl/rstq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstq_pkg
// Shared widths, codes and queue constants of the receive sequence tracker.
// ----------------------------------------------------------------------------
package rstq_pkg;

  // fixed field widths
  localparam int FUNC_W  = 3;
  localparam int ID_W    = 32;
  localparam int LEN_W   = 16;
  localparam int FRAC_W  = 32;
  localparam int KIND_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;
  localparam int SEC_W   = 32;

  // descriptor queue
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // nak run limit
  localparam int MAX_NAKS = 63;
  localparam int NAKS_W   = $clog2(MAX_NAKS + 1);

  // expected id after reset or clear
  localparam logic [ID_W-1:0] ID_START = ID_W'(2);

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_STORE   = 3'd0,
    FUNC_GET     = 3'd1,
    FUNC_FLUSH   = 3'd2,
    FUNC_TIMEOUT = 3'd3,
    FUNC_CLEAR   = 3'd4
  } func_t;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_NAK     = 3'd0,
    KIND_ACK     = 3'd1,
    KIND_STALE   = 3'd2,
    KIND_POPPED  = 3'd3,
    KIND_EMPTY   = 3'd4,
    KIND_FLUSHED = 3'd5,
    KIND_ELAPSED = 3'd6,
    KIND_CLEARED = 3'd7
  } kind_t;

endpackage

// ===== hw/rtl/rstq_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstq_in_if
// Input channel: one packet event or command word with valid/ready.
// ----------------------------------------------------------------------------
interface rstq_in_if import rstq_pkg::*;;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   seq_num;
  logic [LEN_W-1:0]  length_in;
  logic [FRAC_W-1:0] now_fraction;

  modport source (output valid, output func, output seq_num, output length_in,
                  output now_fraction, input ready);
  modport sink   (input valid, input func, input seq_num, input length_in,
                  input now_fraction, output ready);

endinterface

// ===== hw/rtl/rstq_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstq_out_if
// Result channel: one nak, ack or status word with valid/ready.
// ----------------------------------------------------------------------------
interface rstq_out_if import rstq_pkg::*;;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ID_W-1:0]    id_out;
  logic [SLOT_W-1:0]  slot;
  logic [LEN_W-1:0]   length_out;
  logic [COUNT_W-1:0] count;
  logic [SEC_W-1:0]   elapsed_seconds;
  logic               gap_overflow;
  logic               queue_full;
  logic               last;

  modport source (output valid, output kind, output id_out, output slot,
                  output length_out, output count, output elapsed_seconds,
                  output gap_overflow, output queue_full, output last,
                  input ready);
  modport sink   (input valid, input kind, input id_out, input slot,
                  input length_out, input count, input elapsed_seconds,
                  input gap_overflow, input queue_full, input last,
                  output ready);

endinterface

// ===== hw/rtl/rstq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rstq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/rstq_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstq_alu
// Shared 32-bit adder with carry in and carry out. Subtract and compare are
// done by feeding the inverted operand with carry in set.
// ----------------------------------------------------------------------------
module rstq_alu import rstq_pkg::*; (
  input  logic [ID_W-1:0] op_a,
  input  logic [ID_W-1:0] op_b,
  input  logic            carry_in,
  output logic [ID_W-1:0] sum,
  output logic            carry_out
);

  logic [ID_W:0] full_sum;

  // one wide add
  assign full_sum  = {1'b0, op_a} + {1'b0, op_b} + {{ID_W{1'b0}}, carry_in};
  assign sum       = full_sum[ID_W-1:0];
  assign carry_out = full_sum[ID_W];

endmodule

// ===== hw/rtl/rx_sequence_tracker_nak_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_sequence_tracker_nak_queue
// Receive sequence tracker: naks missing ids, acks packets, queues lengths.
// ----------------------------------------------------------------------------
// Steps: a store compares ids, naks each missing id (up to 63), moves the expected
// id and acks; a stale store, empty get, flush and clear give one status word; a
// get reads the queue RAM and pops; a timeout takes four shared adder passes.
// Throughput: one item at a time; the next word is taken once the last result of
// the item is in the output register. Naks leave at one per cycle unless stalled.
// Reset (rst_n low, synchronous): expected id 2, timer and queue cleared; RAM kept.
// ----------------------------------------------------------------------------
module rx_sequence_tracker_nak_queue import rstq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rstq_in_if.sink    in_ch,
  rstq_out_if.source out_ch
);

  // sequencer states
  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_CMP     = 12'b0000_0000_0010,
    S_NAK     = 12'b0000_0000_0100,
    S_EXP     = 12'b0000_0000_1000,
    S_ACK     = 12'b0000_0001_0000,
    S_RD      = 12'b0000_0010_0000,
    S_POP     = 12'b0000_0100_0000,
    S_T_SUB   = 12'b0000_1000_0000,
    S_T_DELTA = 12'b0001_0000_0000,
    S_T_ACC   = 12'b0010_0000_0000,
    S_T_SEC   = 12'b0100_0000_0000,
    S_ONE     = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // tracker state
  logic [ID_W-1:0]   expected_r, expected_nxt;
  logic [FRAC_W-1:0] last_frac_r, last_frac_nxt;
  logic [FRAC_W-1:0] acc_frac_r, acc_frac_nxt;
  logic [SEC_W-1:0]  acc_sec_r, acc_sec_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // per-item working registers
  logic [ID_W-1:0]   pid_r, pid_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [FRAC_W-1:0] now_r, now_nxt;
  logic [ID_W-1:0]   nak_id_r, nak_id_nxt;
  logic [NAKS_W-1:0] naks_left_r, naks_left_nxt;
  logic              gap_big_r, gap_big_nxt;
  logic [FRAC_W-1:0] delta_r, delta_nxt;
  logic              carry_r, carry_nxt;
  kind_t             one_kind_r, one_kind_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [LEN_W-1:0]   out_len_r, out_len_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [SEC_W-1:0]   out_sec_r, out_sec_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic               out_full_r, out_full_nxt;
  logic               out_last_r, out_last_nxt;

  // shared adder
  logic [ID_W-1:0] alu_a, alu_b, alu_sum;
  logic            alu_cin, alu_cout;

  // queue RAM
  logic             ram_wr_en, ram_rd_en;
  logic [LEN_W-1:0] ram_rd_data;

  logic in_fire, emit_ok, queue_full;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign emit_ok     = !out_valid_r || out_ch.ready;
  assign queue_full  = (cnt_r >= CNT_W'(QUEUE_DEPTH));

  rstq_alu u_alu (
    .op_a      (alu_a),
    .op_b      (alu_b),
    .carry_in  (alu_cin),
    .sum       (alu_sum),
    .carry_out (alu_cout)
  );

  rstq_ram #(
    .WIDTH (LEN_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tail_r),
    .wr_data (len_r),
    .rd_en   (ram_rd_en),
    .rd_addr (head_r),
    .rd_data (ram_rd_data)
  );

  // adder operand select per sequencer step
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    case (state_r)
      S_CMP: begin
        alu_a   = pid_r;
        alu_b   = ~expected_r;
        alu_cin = 1'b1;
      end
      S_NAK: begin
        alu_a   = nak_id_r;
        alu_cin = 1'b1;
      end
      S_EXP: begin
        alu_a   = pid_r;
        alu_cin = 1'b1;
      end
      S_T_SUB: begin
        alu_a   = now_r;
        alu_b   = ~last_frac_r;
        alu_cin = 1'b1;
      end
      S_T_DELTA: begin
        // carry clear means now < last: short by one, as the timer defines it
        alu_a   = now_r;
        alu_b   = ~last_frac_r;
        alu_cin = carry_r;
      end
      S_T_ACC: begin
        alu_a = acc_frac_r;
        alu_b = delta_r;
      end
      S_T_SEC: begin
        alu_a   = acc_sec_r;
        alu_cin = carry_r;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    expected_nxt  = expected_r;
    last_frac_nxt = last_frac_r;
    acc_frac_nxt  = acc_frac_r;
    acc_sec_nxt   = acc_sec_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    pid_nxt       = pid_r;
    len_nxt       = len_r;
    now_nxt       = now_r;
    nak_id_nxt    = nak_id_r;
    naks_left_nxt = naks_left_r;
    gap_big_nxt   = gap_big_r;
    delta_nxt     = delta_r;
    carry_nxt     = carry_r;
    one_kind_nxt  = one_kind_r;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_slot_nxt  = out_slot_r;
    out_len_nxt   = out_len_r;
    out_count_nxt = out_count_r;
    out_sec_nxt   = out_sec_r;
    out_ovf_nxt   = out_ovf_r;
    out_full_nxt  = out_full_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pid_nxt = in_ch.seq_num;
          len_nxt = in_ch.length_in;
          now_nxt = in_ch.now_fraction;
          case (in_ch.func)
            FUNC_STORE: state_nxt = S_CMP;
            FUNC_GET: begin
              if (cnt_r == '0) begin
                one_kind_nxt = KIND_EMPTY;
                state_nxt    = S_ONE;
              end else begin
                state_nxt = S_RD;
              end
            end
            FUNC_FLUSH: begin
              one_kind_nxt = KIND_FLUSHED;
              state_nxt    = S_ONE;
            end
            FUNC_TIMEOUT: state_nxt = S_T_SUB;
            FUNC_CLEAR: begin
              one_kind_nxt = KIND_CLEARED;
              state_nxt    = S_ONE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // compare against expected id, restart idle timer
      S_CMP: begin
        last_frac_nxt = now_r;
        acc_frac_nxt  = '0;
        acc_sec_nxt   = '0;
        if (!alu_cout) begin
          one_kind_nxt = KIND_STALE;
          state_nxt    = S_ONE;
        end else begin
          gap_big_nxt = (alu_sum > ID_W'(MAX_NAKS));
          naks_left_nxt = (alu_sum > ID_W'(MAX_NAKS)) ? NAKS_W'(MAX_NAKS)
                                                      : alu_sum[NAKS_W-1:0];
          nak_id_nxt = expected_r;
          state_nxt  = S_NAK;
        end
      end

      // one nak per cycle for missing ids, while the output is not stalled
      S_NAK: begin
        if (naks_left_r == '0) begin
          state_nxt = S_EXP;
        end else if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_NAK;
          out_id_nxt    = nak_id_r;
          out_slot_nxt  = '0;
          out_len_nxt   = '0;
          out_count_nxt = '0;
          out_sec_nxt   = '0;
          out_ovf_nxt   = 1'b0;
          out_full_nxt  = 1'b0;
          out_last_nxt  = 1'b0;
          nak_id_nxt    = alu_sum;
          naks_left_nxt = naks_left_r - NAKS_W'(1);
          if (naks_left_r == NAKS_W'(1)) begin
            state_nxt = S_EXP;
          end
        end
      end

      // move expected id past the packet, skipping zero
      S_EXP: begin
        expected_nxt = (alu_sum == '0) ? ID_W'(1) : alu_sum;
        state_nxt    = S_ACK;
      end

      // ack and push length
      S_ACK: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ACK;
          out_id_nxt    = pid_r;
          out_slot_nxt  = queue_full ? '0 : SLOT_W'(tail_r);
          out_len_nxt   = '0;
          out_count_nxt = '0;
          out_sec_nxt   = '0;
          out_ovf_nxt   = gap_big_r;
          out_full_nxt  = queue_full;
          out_last_nxt  = 1'b1;
          if (!queue_full) begin
            ram_wr_en = 1'b1;
            tail_nxt  = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end

      // queue read, data lands next cycle
      S_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = S_POP;
      end

      S_POP: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_POPPED;
          out_id_nxt    = '0;
          out_slot_nxt  = SLOT_W'(head_r);
          out_len_nxt   = ram_rd_data;
          out_count_nxt = '0;
          out_sec_nxt   = '0;
          out_ovf_nxt   = 1'b0;
          out_full_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
          head_nxt      = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
          cnt_nxt       = cnt_r - CNT_W'(1);
          state_nxt     = S_IDLE;
        end
      end

      // timer: borrow test, delta, fraction add, seconds carry
      S_T_SUB: begin
        carry_nxt = alu_cout;
        state_nxt = S_T_DELTA;
      end

      S_T_DELTA: begin
        delta_nxt = alu_sum;
        state_nxt = S_T_ACC;
      end

      S_T_ACC: begin
        acc_frac_nxt  = alu_sum;
        carry_nxt     = alu_cout;
        last_frac_nxt = now_r;
        state_nxt     = S_T_SEC;
      end

      S_T_SEC: begin
        acc_sec_nxt  = alu_sum;
        one_kind_nxt = KIND_ELAPSED;
        state_nxt    = S_ONE;
      end

      // single status word
      S_ONE: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = one_kind_r;
          out_id_nxt    = '0;
          out_slot_nxt  = '0;
          out_len_nxt   = '0;
          out_count_nxt = '0;
          out_sec_nxt   = '0;
          out_ovf_nxt   = 1'b0;
          out_full_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
          case (one_kind_r)
            KIND_STALE: out_id_nxt = pid_r;
            KIND_FLUSHED: begin
              out_count_nxt = COUNT_W'(cnt_r);
              head_nxt      = tail_r;
              cnt_nxt       = '0;
            end
            KIND_ELAPSED: out_sec_nxt = acc_sec_r;
            KIND_CLEARED: begin
              head_nxt      = '0;
              tail_nxt      = '0;
              cnt_nxt       = '0;
              expected_nxt  = ID_START;
              last_frac_nxt = now_r;
              acc_frac_nxt  = '0;
              acc_sec_nxt   = '0;
            end
            default: out_id_nxt = '0;
          endcase
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control and tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      expected_r  <= ID_START;
      last_frac_r <= '0;
      acc_frac_r  <= '0;
      acc_sec_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      expected_r  <= expected_nxt;
      last_frac_r <= last_frac_nxt;
      acc_frac_r  <= acc_frac_nxt;
      acc_sec_r   <= acc_sec_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    pid_r       <= pid_nxt;
    len_r       <= len_nxt;
    now_r       <= now_nxt;
    nak_id_r    <= nak_id_nxt;
    naks_left_r <= naks_left_nxt;
    gap_big_r   <= gap_big_nxt;
    delta_r     <= delta_nxt;
    carry_r     <= carry_nxt;
    one_kind_r  <= one_kind_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_slot_r  <= out_slot_nxt;
    out_len_r   <= out_len_nxt;
    out_count_r <= out_count_nxt;
    out_sec_r   <= out_sec_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_full_r  <= out_full_nxt;
    out_last_r  <= out_last_nxt;
  end

  // result channel
  assign out_ch.valid           = out_valid_r;
  assign out_ch.kind            = out_kind_r;
  assign out_ch.id_out          = out_id_r;
  assign out_ch.slot            = out_slot_r;
  assign out_ch.length_out      = out_len_r;
  assign out_ch.count           = out_count_r;
  assign out_ch.elapsed_seconds = out_sec_r;
  assign out_ch.gap_overflow    = out_ovf_r;
  assign out_ch.queue_full      = out_full_r;
  assign out_ch.last            = out_last_r;

endmodule

// ===== tb/sv/rx_sequence_tracker_nak_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_sequence_tracker_nak_queue_tb
// Drives packet events and commands into the receive sequence tracker and
// checks every nak, ack and status word against a cycle-free predictor of the
// tracker state: expected id, idle timer and descriptor queue. Directed cases
// come first, then receiver hold-off past a full queue, then random traffic.
// ----------------------------------------------------------------------------
module rx_sequence_tracker_nak_queue_tb;
  import rstq_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int IDLE_PCT     = 9;

  // codes the block ignores
  localparam logic [FUNC_W-1:0] FUNC_RSVD_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_LAST  = 3'd7;

  typedef struct {
    kind_t              kind;
    logic [ID_W-1:0]    id;
    logic [SLOT_W-1:0]  slot;
    logic [LEN_W-1:0]   length;
    logic [COUNT_W-1:0] count;
    logic [SEC_W-1:0]   secs;
    logic               ovf;
    logic               full;
    logic               last;
  } result_t;

  logic clk;
  logic rst_n;

  rstq_in_if  in_ch ();
  rstq_out_if out_ch ();

  rx_sequence_tracker_nak_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // tracker state as predicted
  logic [ID_W-1:0]   trk_next_id;
  logic [FRAC_W-1:0] trk_last_frac;
  logic [FRAC_W-1:0] trk_acc_frac;
  logic [SEC_W-1:0]  trk_acc_sec;
  logic [LEN_W-1:0]  trk_len_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  trk_head;
  logic [PTR_W-1:0]  trk_tail;
  logic [CNT_W-1:0]  trk_fill;

  result_t pending_results [$];

  int          fail_count  = 0;
  int          cycle_count = 0;
  bit          tx_gaps;
  bit          rx_gaps;
  int          hold_len    = 0;
  int          hold_id     = 0;
  int          hold_seen   = 0;
  int          hold_left   = 0;
  logic [31:0] tnow;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side ready: random idling, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_id != hold_seen) begin
      hold_left = hold_len;
      hold_seen = hold_id;
    end
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= !rx_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  function automatic void push_result(kind_t k, logic [ID_W-1:0] id, logic [SLOT_W-1:0] s,
                                      logic [LEN_W-1:0] l, logic [COUNT_W-1:0] c,
                                      logic [SEC_W-1:0] sec, logic ovf, logic full, logic lst);
    result_t r;
    r.kind   = k;
    r.id     = id;
    r.slot   = s;
    r.length = l;
    r.count  = c;
    r.secs   = sec;
    r.ovf    = ovf;
    r.full   = full;
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void reset_tracker();
    trk_next_id   = ID_START;
    trk_last_frac = '0;
    trk_acc_frac  = '0;
    trk_acc_sec   = '0;
    trk_head      = '0;
    trk_tail      = '0;
    trk_fill      = '0;
    foreach (trk_len_mem[i]) trk_len_mem[i] = '0;
  endfunction

  // next tracker state and the words one accepted item causes
  function automatic void track_word(logic [FUNC_W-1:0] f, logic [ID_W-1:0] pid,
                                     logic [LEN_W-1:0] len, logic [FRAC_W-1:0] now);
    logic [ID_W-1:0]   gap;
    logic [ID_W-1:0]   nak_n;
    logic [FRAC_W-1:0] delta;
    logic [FRAC_W:0]   sum;
    logic [SLOT_W-1:0] wslot;
    logic              full;
    case (f)
      FUNC_STORE: begin
        trk_last_frac = now;
        trk_acc_frac  = '0;
        trk_acc_sec   = '0;
        if (pid < trk_next_id) begin
          push_result(KIND_STALE, pid, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          gap   = pid - trk_next_id;
          nak_n = (gap > MAX_NAKS) ? ID_W'(MAX_NAKS) : gap;
          for (int i = 0; i < nak_n; i++)
            push_result(KIND_NAK, trk_next_id + ID_W'(i), '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
          // expected id never lands on 0
          trk_next_id = pid + ID_W'(1);
          if (trk_next_id == '0) trk_next_id = ID_W'(1);
          wslot = '0;
          full  = 1'b0;
          if (trk_fill >= QUEUE_DEPTH) begin
            full = 1'b1;
          end else begin
            wslot = trk_tail;
            trk_len_mem[trk_tail] = len;
            trk_tail = trk_tail + 1'b1;
            trk_fill = trk_fill + 1'b1;
          end
          push_result(KIND_ACK, pid, wslot, '0, '0, '0, gap > MAX_NAKS, full, 1'b1);
        end
      end
      FUNC_GET: begin
        if (trk_fill == '0) begin
          push_result(KIND_EMPTY, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          push_result(KIND_POPPED, '0, trk_head, trk_len_mem[trk_head], '0, '0,
                      1'b0, 1'b0, 1'b1);
          trk_head = trk_head + 1'b1;
          trk_fill = trk_fill - 1'b1;
        end
      end
      FUNC_FLUSH: begin
        push_result(KIND_FLUSHED, '0, '0, '0, COUNT_W'(trk_fill), '0, 1'b0, 1'b0, 1'b1);
        trk_head = trk_tail;
        trk_fill = '0;
      end
      FUNC_TIMEOUT: begin
        // wrapped delta is one short of the true difference
        if (now < trk_last_frac) delta = 32'hffff_ffff - trk_last_frac + now;
        else delta = now - trk_last_frac;
        sum = {1'b0, trk_acc_frac} + {1'b0, delta};
        if (sum[FRAC_W]) trk_acc_sec = trk_acc_sec + SEC_W'(1);
        trk_acc_frac  = sum[FRAC_W-1:0];
        trk_last_frac = now;
        push_result(KIND_ELAPSED, '0, '0, '0, '0, trk_acc_sec, 1'b0, 1'b0, 1'b1);
      end
      FUNC_CLEAR: begin
        trk_head      = '0;
        trk_tail      = '0;
        trk_fill      = '0;
        trk_next_id   = ID_START;
        trk_last_frac = now;
        trk_acc_frac  = '0;
        trk_acc_sec   = '0;
        push_result(KIND_CLEARED, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: kind %0d id 0x%0h", out_ch.kind, out_ch.id_out);
        fail_count++;
      end else begin
        r = pending_results.pop_front();
        check_field("kind", 32'(r.kind), 32'(out_ch.kind));
        check_field("id_out", r.id, out_ch.id_out);
        check_field("slot", 32'(r.slot), 32'(out_ch.slot));
        check_field("length_out", 32'(r.length), 32'(out_ch.length_out));
        check_field("count", 32'(r.count), 32'(out_ch.count));
        check_field("elapsed_seconds", r.secs, out_ch.elapsed_seconds);
        check_field("gap_overflow", 32'(r.ovf), 32'(out_ch.gap_overflow));
        check_field("queue_full", 32'(r.full), 32'(out_ch.queue_full));
        check_field("last", 32'(r.last), 32'(out_ch.last));
      end
    end
  end

  // offer one word, hold it until accepted, then predict its results
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] pid,
                           input logic [LEN_W-1:0] len, input logic [FRAC_W-1:0] now);
    if (tx_gaps) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.seq_num      <= pid;
    in_ch.length_in    <= len;
    in_ch.now_fraction <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_word(f, pid, len, now);
  endtask

  // sender goes quiet until every predicted word is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_store(input logic [ID_W-1:0] pid, input logic [LEN_W-1:0] len);
    send_word(FUNC_STORE, pid, len, tnow);
  endtask

  // ids in order, gaps at the nak limit, stale ids, id wrap, pops and flush
  task automatic test_sequence_directed();
    send_store(32'd2, 16'h0000);
    send_store(32'd5, 16'hffff);
    send_store(32'd4, 16'h1234);
    send_store(32'd6 + 32'd63, 16'h00ff);
    send_store(trk_next_id + 32'd64, 16'hff00);
    send_store(32'hffff_ffff, 16'h5a5a);
    send_store(32'd0, 16'ha5a5);
    send_store(32'd1, 16'h0001);
    send_word(FUNC_GET, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    send_word(FUNC_GET, '0, '0, '0);
    send_word(FUNC_FLUSH, '0, '0, '0);
    send_word(FUNC_GET, '0, '0, '0);
    send_word(FUNC_FLUSH, '0, '0, '0);
    wait_drained();
  endtask

  // idle timer: wrapped delta, carry into seconds, largest delta
  task automatic test_timer_directed();
    send_word(FUNC_CLEAR, '0, '0, 32'h0000_0010);
    send_word(FUNC_TIMEOUT, '0, '0, 32'h0000_0008);
    send_word(FUNC_TIMEOUT, '0, '0, 32'h0000_0020);
    send_word(FUNC_TIMEOUT, '0, '0, 32'h0000_0020);
    send_word(FUNC_STORE, trk_next_id, 16'h0042, 32'h0000_0000);
    send_word(FUNC_TIMEOUT, '0, '0, 32'hffff_ffff);
    wait_drained();
  endtask

  // unused codes leave the tracker alone
  task automatic test_unused_codes();
    for (logic [FUNC_W:0] f = (FUNC_W+1)'(FUNC_RSVD_FIRST);
         f <= (FUNC_W+1)'(FUNC_RSVD_LAST); f++)
      send_word(f[FUNC_W-1:0], $urandom, LEN_W'($urandom), $urandom);
    send_word(FUNC_GET, '0, '0, '0);
    wait_drained();
  endtask

  // receiver holds off at first, and stores go on past a full queue
  task automatic test_backpressure_full();
    send_word(FUNC_CLEAR, '0, '0, tnow);
    hold_len = 400;
    hold_id++;
    for (int i = 0; i < QUEUE_DEPTH + 3; i++)
      send_store(trk_next_id + ID_W'($urandom_range(0, 2)), LEN_W'($urandom));
    send_word(FUNC_GET, '0, '0, '0);
    send_store(trk_next_id, LEN_W'($urandom));
    send_store(trk_next_id, LEN_W'($urandom));
    send_word(FUNC_FLUSH, '0, '0, '0);
    wait_drained();
  endtask

  // mostly in-order traffic with random gaps, plus stale ids and commands
  task automatic run_random(input int n_items);
    int                sel;
    int                gsel;
    logic [ID_W-1:0]   pid;
    logic [ID_W-1:0]   gap;
    int                done;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 99) < 20) tnow = $urandom;
      else tnow = tnow + $urandom_range(0, 32'h3fff_ffff);
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        gsel = $urandom_range(0, 99);
        if (gsel < 70) gap = '0;
        else if (gsel < 90) gap = $urandom_range(1, 4);
        else if (gsel < 97) gap = $urandom_range(5, 70);
        else gap = $urandom;
        pid = trk_next_id + gap;
        // jump close to the top so the expected id wraps soon
        if ($urandom_range(0, 99) < 2) pid = 32'hffff_ffff - $urandom_range(0, 20);
        send_store(pid, LEN_W'($urandom));
      end else if (sel < 63) begin
        send_store($urandom_range(0, trk_next_id - 1), LEN_W'($urandom));
      end else if (sel < 78) begin
        send_word(FUNC_GET, $urandom, LEN_W'($urandom), $urandom);
      end else if (sel < 82) begin
        send_word(FUNC_FLUSH, $urandom, LEN_W'($urandom), $urandom);
      end else if (sel < 92) begin
        send_word(FUNC_TIMEOUT, $urandom, LEN_W'($urandom), tnow);
      end else if (sel < 95) begin
        send_word(FUNC_CLEAR, $urandom, LEN_W'($urandom), tnow);
      end else begin
        send_word(FUNC_RSVD_FIRST + FUNC_W'($urandom_range(0, 2)),
                  $urandom, LEN_W'($urandom), $urandom);
        done--;
      end
      done++;
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_STORE;
    in_ch.seq_num      = '0;
    in_ch.length_in    = '0;
    in_ch.now_fraction = '0;
    tnow               = '0;
    tx_gaps            = 1'b1;
    rx_gaps            = 1'b1;
    reset_tracker();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_sequence_directed();
    test_timer_directed();
    test_unused_codes();
    test_backpressure_full();
    run_random(170);
    // a stretch with both sides always ready
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_random(60);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    run_random(170);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rstq_pkg.sv
hw/rtl/rstq_in_if.sv
hw/rtl/rstq_out_if.sv
hw/rtl/rstq_ram.sv
hw/rtl/rstq_alu.sv
hw/rtl/rx_sequence_tracker_nak_queue.sv
tb/sv/rx_sequence_tracker_nak_queue_tb.sv
